FILE: sv/bce_pkg.sv
// Package for the battery charge estimator: field widths, voltage table
// limits, register indexes and reset values. No dependencies.
package bce_pkg;

    localparam int UPTIME_W  = 32;
    localparam int VOLT_W    = 16;
    localparam int CHARGE_W  = 32;
    localparam int CURRENT_W = 16;
    localparam int PCT_W     = 14;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [VOLT_W-1:0] MV_EMPTY = 16'd3500;
    localparam logic [VOLT_W-1:0] MV_FULL  = 16'd4200;
    localparam logic [PCT_W-1:0]  PCT_FULL = 14'd10000;

    // (v - 3500) * 100 / 7 = 14 * d + (2 * d) / 7, with d < 700
    localparam int SPAN_W      = 10;
    localparam int FRAC_PROD_W = 23;
    localparam int RECIP_SHIFT = 15;
    localparam logic [FRAC_PROD_W-1:0] RECIP_7  = 23'd4682;
    localparam logic [PCT_W-1:0]       SLOPE_INT = 14'd14;

    localparam logic [PCT_W-1:0]    SLEEP_THR_RST  = 14'd1000;
    localparam logic [PCT_W-1:0]    RESUME_THR_RST = 14'd2000;
    localparam logic [CFG_W-1:0]    QUERY_INT_RST  = 32'd10000;
    localparam logic [CFG_W-1:0]    ALERT_INT_RST  = 32'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAUGE_AVAILABLE  = 3'd0,
        CFG_SLEEP_ENABLE     = 3'd1,
        CFG_SLEEP_THRESHOLD  = 3'd2,
        CFG_RESUME_THRESHOLD = 3'd3,
        CFG_QUERY_INTERVAL   = 3'd4,
        CFG_ALERT_INTERVAL   = 3'd5
    } cfg_idx_t;

endpackage

FILE: sv/bce_if.sv
// Handshake channels of the battery charge estimator: poll in, result out.
// Depends on bce_pkg for field widths.
interface bce_poll_if
    import bce_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [UPTIME_W-1:0]         uptime_ms;
    logic [VOLT_W-1:0]           voltage_mv;
    logic signed [CHARGE_W-1:0]  charge_count;
    logic signed [CURRENT_W-1:0] current_ma;

    modport source (output valid, uptime_ms, voltage_mv, charge_count, current_ma,
                    input ready);
    modport sink   (input valid, uptime_ms, voltage_mv, charge_count, current_ma,
                    output ready);
endinterface

interface bce_result_if
    import bce_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic                        sampled;
    logic                        attached;
    logic                        is_low;
    logic                        is_ok;
    logic [PCT_W-1:0]            percent_x100;
    logic [VOLT_W-1:0]           voltage_out_mv;
    logic signed [CHARGE_W-1:0]  charge_delta;
    logic signed [CURRENT_W-1:0] current_out_ma;
    logic                        low_power_event;

    modport source (output valid, sampled, attached, is_low, is_ok, percent_x100,
                    voltage_out_mv, charge_delta, current_out_ma, low_power_event,
                    input ready);
    modport sink   (input valid, sampled, attached, is_low, is_ok, percent_x100,
                    voltage_out_mv, charge_delta, current_out_ma, low_power_event,
                    output ready);
endinterface

FILE: sv/battery_charge_estimator_core.sv
// Battery charge estimator top level: sample gating, voltage to charge
// mapping, charge delta and alert rate limiting. Depends on bce_pkg, bce_if.
//
// Every poll beat yields exactly one result beat. A poll is taken in any
// cycle in which the result register is empty or being drained, so the block
// sustains one poll per clock; the result is registered for the cycle after the poll.
// The only storage between beats is the query time, last charge and last alert
// time registers, updated at the edge that accepts a due poll. Configuration
// writes take effect at the next edge.
module battery_charge_estimator_core
    import bce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bce_poll_if.sink             poll,
    bce_result_if.source         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic                gauge_available_reg;
    logic                sleep_enable_reg;
    logic [PCT_W-1:0]    sleep_thr_reg;
    logic [PCT_W-1:0]    resume_thr_reg;
    logic [CFG_W-1:0]    query_int_reg;
    logic [CFG_W-1:0]    alert_int_reg;

    logic [UPTIME_W-1:0] next_query_reg;
    logic [CHARGE_W-1:0] last_charge_reg;
    logic [UPTIME_W-1:0] last_alert_reg;

    logic                        out_valid_reg;
    logic                        sampled_reg;
    logic                        attached_reg;
    logic                        is_low_reg;
    logic                        is_ok_reg;
    logic [PCT_W-1:0]            pct_reg;
    logic [VOLT_W-1:0]           volt_reg;
    logic signed [CHARGE_W-1:0]  delta_reg;
    logic signed [CURRENT_W-1:0] current_reg;
    logic                        event_reg;

    logic                   accept;
    logic                   query_due;
    logic                   take_sample;
    logic                   alert_due;
    logic [VOLT_W-1:0]      volt_diff;
    logic [SPAN_W-1:0]      span;
    logic [FRAC_PROD_W-1:0] frac_prod;
    logic [PCT_W-1:0]       pct_lin;
    logic [PCT_W-1:0]       pct;
    logic                   attached;
    logic                   is_low;
    logic                   is_ok;
    logic [CHARGE_W-1:0]    delta;
    logic [UPTIME_W-1:0]    since_alert;

    assign poll.ready = !out_valid_reg || result.ready;
    assign accept     = poll.valid && poll.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gauge_available_reg <= 1'b0;
            sleep_enable_reg    <= 1'b0;
            sleep_thr_reg       <= SLEEP_THR_RST;
            resume_thr_reg      <= RESUME_THR_RST;
            query_int_reg       <= QUERY_INT_RST;
            alert_int_reg       <= ALERT_INT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAUGE_AVAILABLE:  gauge_available_reg <= cfg_data[0];
                CFG_SLEEP_ENABLE:     sleep_enable_reg    <= cfg_data[0];
                CFG_SLEEP_THRESHOLD:  sleep_thr_reg       <= cfg_data[PCT_W-1:0];
                CFG_RESUME_THRESHOLD: resume_thr_reg      <= cfg_data[PCT_W-1:0];
                CFG_QUERY_INTERVAL:   query_int_reg       <= cfg_data;
                CFG_ALERT_INTERVAL:   alert_int_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample gating
    assign query_due   = poll.uptime_ms > next_query_reg;
    assign take_sample = query_due && gauge_available_reg;
    assign since_alert = poll.uptime_ms - last_alert_reg;
    assign alert_due   = since_alert > alert_int_reg;

    // Voltage to charge: 14 * d + (2 * d) / 7 via reciprocal multiply
    assign volt_diff = poll.voltage_mv - MV_EMPTY;
    assign span      = volt_diff[SPAN_W-1:0];
    assign frac_prod = FRAC_PROD_W'({span, 1'b0}) * RECIP_7;
    assign pct_lin   = PCT_W'(span) * SLOPE_INT
                     + PCT_W'(frac_prod[FRAC_PROD_W-1:RECIP_SHIFT]);

    always_comb
    begin
        if (poll.voltage_mv < MV_EMPTY)
            pct = '0;
        else if (poll.voltage_mv >= MV_FULL)
            pct = PCT_FULL;
        else
            pct = pct_lin;
    end

    assign attached = poll.voltage_mv >= MV_EMPTY;
    assign is_low   = pct < sleep_thr_reg;
    assign is_ok    = pct > resume_thr_reg;
    assign delta    = (next_query_reg == '0) ? '0
                    : CHARGE_W'(poll.charge_count) - last_charge_reg;

    // Sample state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_query_reg  <= '0;
            last_charge_reg <= '0;
            last_alert_reg  <= '0;
        end
        else if (accept && query_due)
        begin
            next_query_reg <= poll.uptime_ms + query_int_reg;
            if (gauge_available_reg)
            begin
                last_charge_reg <= CHARGE_W'(poll.charge_count);
                if (alert_due)
                    last_alert_reg <= poll.uptime_ms;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (poll.ready)
            out_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sampled_reg  <= take_sample;
            attached_reg <= take_sample && attached;
            is_low_reg   <= take_sample && is_low;
            is_ok_reg    <= take_sample && is_ok;
            pct_reg      <= take_sample ? pct : '0;
            volt_reg     <= take_sample ? poll.voltage_mv : '0;
            delta_reg    <= take_sample ? $signed(delta) : '0;
            current_reg  <= take_sample ? poll.current_ma : '0;
            event_reg    <= take_sample && alert_due && is_low && sleep_enable_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.sampled         = sampled_reg;
    assign result.attached        = attached_reg;
    assign result.is_low          = is_low_reg;
    assign result.is_ok           = is_ok_reg;
    assign result.percent_x100    = pct_reg;
    assign result.voltage_out_mv  = volt_reg;
    assign result.charge_delta    = delta_reg;
    assign result.current_out_ma  = current_reg;
    assign result.low_power_event = event_reg;

endmodule

FILE: sv/bce_checker.sv
// Port-level checks for the battery charge estimator, bound to the top level.
// Depends on bce_pkg.
module bce_checker
    import bce_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 poll_ready,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic                 sampled,
    input logic                 attached,
    input logic                 is_low,
    input logic [PCT_W-1:0]     percent_x100,
    input logic [CHARGE_W-1:0]  charge_delta,
    input logic                 low_power_event
);

    // A beat without a sample carries nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !sampled |-> percent_x100 == '0 && !attached
            && charge_delta == '0 && !low_power_event)
        else $error("unsampled result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sampled |-> percent_x100 <= PCT_FULL
            && (attached || percent_x100 == '0))
        else $error("charge out of range for voltage");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && low_power_event |-> is_low && sampled)
        else $error("low-power event without low battery");

    // Hold the poll side while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !poll_ready)
        else $error("poll accepted over a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(percent_x100)
            && $stable(charge_delta))
        else $error("stalled result changed");

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .poll_ready      (poll.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .sampled         (result.sampled),
    .attached        (result.attached),
    .is_low          (result.is_low),
    .percent_x100    (result.percent_x100),
    .charge_delta    (result.charge_delta),
    .low_power_event (result.low_power_event)
);

FILE: verif/battery_charge_estimator_core_tb.sv
// Self-checking testbench for battery_charge_estimator_core: directed polls,
// then randomized polls under several register settings with bursty input and
// stalled output. Depends on bce_pkg, bce_if and the core itself.
module battery_charge_estimator_core_tb;
    import bce_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [UPTIME_W-1:0]         uptime_ms;
        logic [VOLT_W-1:0]           voltage_mv;
        logic signed [CHARGE_W-1:0]  charge_count;
        logic signed [CURRENT_W-1:0] current_ma;
    } poll_t;

    typedef struct packed {
        logic                        sampled;
        logic                        attached;
        logic                        is_low;
        logic                        is_ok;
        logic [PCT_W-1:0]            percent_x100;
        logic [VOLT_W-1:0]           voltage_mv;
        logic signed [CHARGE_W-1:0]  charge_delta;
        logic signed [CURRENT_W-1:0] current_ma;
        logic                        low_power_event;
    } charge_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    bce_poll_if   poll_bus ();
    bce_result_if result_bus ();

    battery_charge_estimator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // register copies
    logic             gauge_on   = 1'b0;
    logic             sleep_on   = 1'b0;
    logic [PCT_W-1:0] sleep_thr  = SLEEP_THR_RST;
    logic [PCT_W-1:0] resume_thr = RESUME_THR_RST;
    logic [CFG_W-1:0] query_gap  = QUERY_INT_RST;
    logic [CFG_W-1:0] alert_gap  = ALERT_INT_RST;

    // estimator state
    logic [UPTIME_W-1:0]        query_due   = '0;
    logic signed [CHARGE_W-1:0] charge_seen = '0;
    logic [UPTIME_W-1:0]        alert_stamp = '0;

    poll_t          polls_pending[$];
    charge_report_t reports_due[$];

    int          burst_left     = 1;
    int          gap_left       = 0;
    int          stall_mode     = 0;
    int          stall_left     = 0;
    int          tick           = 0;
    int          idle_cycles    = 0;
    int          mismatch_count = 0;
    logic [31:0] poll_clock     = '0;

    function automatic charge_report_t estimate_charge(poll_t p);
        charge_report_t r;
        logic [31:0]    pct;
        logic [31:0]    since_alert;
        logic           low;
        r = '0;
        if (p.uptime_ms > query_due) begin
            if (gauge_on) begin
                if (p.voltage_mv < MV_EMPTY)
                    pct = 32'd0;
                else if (p.voltage_mv >= MV_FULL)
                    pct = {18'd0, PCT_FULL};
                else
                    pct = (({16'd0, p.voltage_mv} - {16'd0, MV_EMPTY}) * 32'd100) / 32'd7;
                low = pct < {18'd0, sleep_thr};
                r.sampled      = 1'b1;
                r.attached     = p.voltage_mv >= MV_EMPTY;
                r.is_low       = low;
                r.is_ok        = pct > {18'd0, resume_thr};
                r.percent_x100 = pct[PCT_W-1:0];
                r.voltage_mv   = p.voltage_mv;
                r.charge_delta = (query_due == '0) ? '0 : p.charge_count - charge_seen;
                r.current_ma   = p.current_ma;
                charge_seen    = p.charge_count;
                since_alert    = p.uptime_ms - alert_stamp;
                if (since_alert > alert_gap) begin
                    r.low_power_event = low & sleep_on;
                    alert_stamp       = p.uptime_ms;
                end
            end
            query_due = p.uptime_ms + query_gap;
        end
        return r;
    endfunction

    function automatic string fmt_report(charge_report_t r);
        return $sformatf("smp=%0b att=%0b low=%0b ok=%0b pct=%0d mv=%0d dq=%0d ma=%0d evt=%0b",
                         r.sampled, r.attached, r.is_low, r.is_ok, r.percent_x100,
                         r.voltage_mv, r.charge_delta, r.current_ma, r.low_power_event);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_GAUGE_AVAILABLE:  gauge_on   = val[0];
            CFG_SLEEP_ENABLE:     sleep_on   = val[0];
            CFG_SLEEP_THRESHOLD:  sleep_thr  = val[PCT_W-1:0];
            CFG_RESUME_THRESHOLD: resume_thr = val[PCT_W-1:0];
            CFG_QUERY_INTERVAL:   query_gap  = val;
            CFG_ALERT_INTERVAL:   alert_gap  = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic gauge, logic sleep, logic [PCT_W-1:0] sleep_lvl,
                             logic [PCT_W-1:0] resume_lvl, logic [CFG_W-1:0] query,
                             logic [CFG_W-1:0] alert);
        write_reg(CFG_GAUGE_AVAILABLE, {31'd0, gauge});
        write_reg(CFG_SLEEP_ENABLE, {31'd0, sleep});
        write_reg(CFG_SLEEP_THRESHOLD, {18'd0, sleep_lvl});
        write_reg(CFG_RESUME_THRESHOLD, {18'd0, resume_lvl});
        write_reg(CFG_QUERY_INTERVAL, query);
        write_reg(CFG_ALERT_INTERVAL, alert);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        poll_clock = query_due;
    endtask

    task automatic push_poll(logic [31:0] up, logic [15:0] mv, logic [31:0] chg,
                             logic [15:0] cur);
        poll_t p;
        p.uptime_ms    = up;
        p.voltage_mv   = mv;
        p.charge_count = chg;
        p.current_ma   = cur;
        polls_pending.push_back(p);
    endtask

    // hold until every poll is sent and every report is back
    task automatic settle();
        while (polls_pending.size() != 0 || poll_bus.valid === 1'b1 || reports_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic queue_random_polls(int count, int unsigned step_max);
        logic [15:0] mv;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                poll_clock += $urandom_range(1, step_max);
            else if (pick < 85)
                poll_clock = poll_clock;
            else if (pick < 96)
                poll_clock -= $urandom_range(1, step_max);
            else
                poll_clock += $urandom_range(0, 32'h000F_FFFF);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                mv = 16'($urandom_range(3400, 4300));
            else if (pick < 85)
                mv = 16'($urandom);
            else if (pick < 93)
                mv = MV_EMPTY - 16'd1 + 16'($urandom_range(0, 2));
            else
                mv = MV_FULL - 16'd1 + 16'($urandom_range(0, 2));
            push_poll(poll_clock, mv, $urandom, 16'($urandom));
        end
    endtask

    // poll driver
    always @(posedge clk) begin : drive_polls
        poll_t nxt;
        if (!rst_n) begin
            poll_bus.valid <= 1'b0;
        end
        else begin
            if (poll_bus.valid && poll_bus.ready)
                reports_due.push_back(estimate_charge({poll_bus.uptime_ms, poll_bus.voltage_mv,
                                                       poll_bus.charge_count,
                                                       poll_bus.current_ma}));
            if (!poll_bus.valid || poll_bus.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    poll_bus.valid <= 1'b0;
                end
                else if (polls_pending.size() != 0) begin
                    nxt = polls_pending.pop_front();
                    poll_bus.uptime_ms    <= nxt.uptime_ms;
                    poll_bus.voltage_mv   <= nxt.voltage_mv;
                    poll_bus.charge_count <= nxt.charge_count;
                    poll_bus.current_ma   <= nxt.current_ma;
                    poll_bus.valid        <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    end
                    else begin
                        burst_left--;
                    end
                end
                else begin
                    poll_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
        end
        else begin
            tick++;
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end
            else begin
                stall_left--;
            end
            case (stall_mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= 1'($urandom_range(0, 1));
                2:       result_bus.ready <= (tick % 4) == 0;
                default: result_bus.ready <= $urandom_range(0, 99) < 85;
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin : check_reports
        charge_report_t got;
        charge_report_t want;
        if (rst_n && result_bus.valid && result_bus.ready) begin
            got.sampled         = result_bus.sampled;
            got.attached        = result_bus.attached;
            got.is_low          = result_bus.is_low;
            got.is_ok           = result_bus.is_ok;
            got.percent_x100    = result_bus.percent_x100;
            got.voltage_mv      = result_bus.voltage_out_mv;
            got.charge_delta    = result_bus.charge_delta;
            got.current_ma      = result_bus.current_out_ma;
            got.low_power_event = result_bus.low_power_event;
            if (reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %s", fmt_report(got));
            end
            else begin
                want = reports_due.pop_front();
                if (got.sampled !== want.sampled || got.attached !== want.attached
                    || got.is_low !== want.is_low || got.is_ok !== want.is_ok
                    || got.percent_x100 !== want.percent_x100
                    || got.voltage_mv !== want.voltage_mv
                    || got.charge_delta !== want.charge_delta
                    || got.current_ma !== want.current_ma
                    || got.low_power_event !== want.low_power_event) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch at %0t\n  expected %s\n  actual   %s",
                                 $time, fmt_report(want), fmt_report(got));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((poll_bus.valid && poll_bus.ready) || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** battery_charge_estimator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_GAUGE_AVAILABLE;
        cfg_data                = '0;
        poll_bus.valid          = 1'b0;
        poll_bus.uptime_ms      = '0;
        poll_bus.voltage_mv     = '0;
        poll_bus.charge_count   = '0;
        poll_bus.current_ma     = '0;
        result_bus.ready        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // table corners, thresholds, first sample and uptime wrap
        configure(1'b1, 1'b1, 14'd1000, 14'd2000, 32'd1, 32'd0);
        push_poll(32'd0, 16'd3700, 32'd5, 16'd1);
        push_poll(32'd1, 16'd0, 32'h7FFF_FFFF, 16'h8000);
        push_poll(32'd2, 16'd3499, 32'h8000_0000, 16'h7FFF);
        push_poll(32'd3, 16'd3499, 32'h8000_0000, 16'h7FFF);
        push_poll(32'd5, 16'd3500, 32'd0, 16'd0);
        push_poll(32'd7, 16'd3501, 32'hFFFF_FFFF, 16'hFFFF);
        push_poll(32'd9, 16'd3507, 32'd100, 16'd250);
        push_poll(32'd11, 16'd3570, 32'd90, 16'hFF00);
        push_poll(32'd13, 16'd3571, 32'd80, 16'd12);
        push_poll(32'd15, 16'd3640, 32'd70, 16'd13);
        push_poll(32'd17, 16'd3641, 32'd60, 16'd14);
        push_poll(32'd19, 16'd4199, 32'd50, 16'd15);
        push_poll(32'd21, 16'd4200, 32'd40, 16'd16);
        push_poll(32'd23, 16'hFFFF, 32'h5555_AAAA, 16'h55AA);
        push_poll(32'd23, 16'd3800, 32'd7, 16'd7);
        push_poll(32'd22, 16'd3800, 32'd7, 16'd7);
        push_poll(32'hFFFF_FFFF, 16'd3600, 32'hAAAA_5555, 16'hAA55);
        push_poll(32'd0, 16'd3600, 32'd1, 16'd1);
        push_poll(32'd4, 16'd3800, 32'd12345, 16'd2);
        settle();

        // gauge absent still advances the query time
        configure(1'b0, 1'b1, 14'd1000, 14'd2000, 32'd100, 32'd60000);
        push_poll(32'd10, 16'd3550, 32'd3, 16'd3);
        push_poll(32'd50, 16'd3550, 32'd4, 16'd4);
        push_poll(32'd111, 16'd3550, 32'd5, 16'd5);
        settle();
        configure(1'b1, 1'b0, 14'd1000, 14'd2000, 32'd100, 32'd60000);
        push_poll(32'd212, 16'd3550, 32'd6, 16'd6);
        push_poll(32'd213, 16'd3550, 32'd7, 16'd7);
        settle();

        configure(1'b1, 1'b1, 14'd1000, 14'd2000, 32'd100, 32'd250);
        queue_random_polls(80, 200);
        settle();

        configure(1'b1, 1'b0, 14'd10000, 14'd0, 32'd0, 32'd0);
        queue_random_polls(70, 4);
        settle();

        configure(1'b1, 1'b1, 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                  $urandom_range(1, 400), $urandom_range(0, 1000));
        queue_random_polls(80, 500);
        settle();

        configure(1'b0, 1'b1, 14'd3000, 14'd4000, 32'd50, 32'd100);
        queue_random_polls(20, 100);
        settle();

        configure(1'b1, 1'b1, 14'h3FFF, 14'h3FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random_polls(70, 5);
        settle();

        configure(1'b1, 1'b1, 14'($urandom_range(500, 3000)), 14'($urandom_range(1500, 6000)),
                  $urandom_range(0, 50), $urandom_range(0, 200));
        queue_random_polls(110, 80);
        settle();

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("** battery_charge_estimator_core: PASSED **");
        else
            $display("** battery_charge_estimator_core: FAILED **");
        $finish;
    end

endmodule
